// ----- rtl/core/dda_pkg.sv -----
// Shared types and constants for the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE
    } dda_state_t;

    // Strobes from the sequencer to the pixel generator.
    typedef struct packed {
        logic load_pos;
        logic load_step;
        logic advance;
    } dda_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/dda_div.sv -----
// Bit-serial restoring divider producing one quotient bit per cycle while enable is high.
`timescale 1ns / 1ps
`default_nettype none

module dda_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   start,
    input  wire logic                   enable,
    input  wire logic [COORD_BITS-1:0]  mag,
    input  wire logic [COORD_BITS-1:0]  len,
    output logic      [FRAC_BITS:0]     quot
);

    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] len_reg;
    logic [FRAC_BITS:0]    quot_reg, quot_next;
    logic [COORD_BITS+1:0] diff;
    logic [COORD_BITS:0]   rem_sel;
    logic                  q_bit;

    // The span never exceeds len, so the partial remainder starts as the span itself.
    always_comb begin
        diff      = {1'b0, rem_reg} - {2'b00, len_reg};
        q_bit     = ~diff[COORD_BITS+1];
        rem_sel   = q_bit ? diff[COORD_BITS:0] : rem_reg;
        rem_next  = {rem_sel[COORD_BITS-1:0], 1'b0};
        quot_next = {quot_reg[FRAC_BITS-1:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, mag};
            len_reg  <= len;
            quot_reg <= '0;
        end else if (enable) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dda_pix.sv -----
// Pixel generator: position accumulators, increments and the output register.
`timescale 1ns / 1ps
`default_nettype none

module dda_pix
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dda_ctl_t               ctl,
    input  wire logic [COORD_BITS-1:0]  start_x,
    input  wire logic [COORD_BITS-1:0]  start_y,
    input  wire logic [FRAC_BITS+1:0]   step_x,
    input  wire logic [FRAC_BITS+1:0]   step_y,
    input  wire logic                   last_in,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic      [COORD_BITS-1:0]  pixel_x,
    output logic      [COORD_BITS-1:0]  pixel_y,
    output logic                        last
);

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS;

    logic [ACC_BITS-1:0]   x_acc_reg, y_acc_reg;
    logic [ACC_BITS-1:0]   x_acc_next, y_acc_next;
    logic [FRAC_BITS+1:0]  x_step_reg, y_step_reg;
    logic [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    logic                  last_reg;
    logic                  valid_reg;

    // Increments are sign-extended to the accumulator width; the sum wraps.
    always_comb begin
        x_acc_next = x_acc_reg + {{(ACC_BITS-FRAC_BITS-2){x_step_reg[FRAC_BITS+1]}}, x_step_reg};
        y_acc_next = y_acc_reg + {{(ACC_BITS-FRAC_BITS-2){y_step_reg[FRAC_BITS+1]}}, y_step_reg};
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_pos) begin
            x_acc_reg <= {start_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
            y_acc_reg <= {start_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
        end else if (ctl.advance) begin
            x_acc_reg <= x_acc_next;
            y_acc_reg <= y_acc_next;
        end
        if (ctl.load_step) begin
            x_step_reg <= step_x;
            y_step_reg <= step_y;
        end
        if (ctl.advance) begin
            pix_x_reg <= x_acc_reg[ACC_BITS-1:FRAC_BITS];
            pix_y_reg <= y_acc_reg[ACC_BITS-1:FRAC_BITS];
            last_reg  <= last_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.advance) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_x   = pix_x_reg;
    assign pixel_y   = pix_y_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dda_line_rasterizer.sv -----
// Top level of the DDA line rasterizer: sequencer, line counters and stream ports.
// Load: a load transaction keeps s_tready low while the two bit-serial dividers produce their
// FRAC_BITS + 1 quotient bits in ST_DIVIDE and the increments are stored in ST_STORE.
// Throughput: step transactions are taken one per cycle while m_tready keeps up; each pixel
// is on m_tdata the cycle after its step is accepted; the output register lets the next step in.
// Reset (aresetn low at a clock edge, synchronous) drops any line and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input stream. tdata from bit 0: start_x, start_y, end_x, end_y, zero padding.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // tuser: operation (load new endpoints or request the next pixel).
    input  wire logic                                  s_tuser,
    // Result stream. tdata from bit 0: pixel_x, pixel_y, zero padding.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                       m_tlast
);

    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int CNT_W = $clog2(FRAC_BITS+1);

    dda_state_t state_reg, state_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS:0]   pixels_left_reg, pixels_left_next;
    logic                  line_active_reg, line_active_next;
    logic                  neg_x_reg, neg_y_reg, len_zero_reg;

    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS-1:0] adx, ady, len;
    logic                  in_acc, load_acc, step_acc;
    logic                  last_pix;
    logic                  div_start, div_en;
    logic [FRAC_BITS:0]    quot_x, quot_y;
    logic [FRAC_BITS+1:0]  step_x, step_y;
    logic [COORD_BITS-1:0] pixel_x, pixel_y;
    dda_ctl_t              ctl;

    // Unpack the endpoint fields; bits beyond the four coordinates are ignored.
    assign sx = s_tdata[COORD_BITS-1:0];
    assign sy = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign ex = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign ey = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // Spans and line length: the longer axis decides how many pixels the line gets.
    assign adx = (ex >= sx) ? (ex - sx) : (sx - ex);
    assign ady = (ey >= sy) ? (ey - sy) : (sy - ey);
    assign len = (adx >= ady) ? adx : ady;

    // Input is taken only in idle, and only when the output register is free or draining.
    assign s_tready = (state_reg == ST_IDLE) & (~m_tvalid | m_tready);

    assign in_acc   = s_tvalid & s_tready;
    assign load_acc = in_acc & (s_tuser == OP_LOAD);
    assign step_acc = in_acc & (s_tuser == OP_STEP);
    assign last_pix = (pixels_left_reg <= (COORD_BITS+1)'(1));

    // The dividers deliver the increment magnitudes; the sign of the span is applied
    // afterwards. A line of zero length gets no increment at all.
    always_comb begin
        step_x = {1'b0, quot_x};
        step_y = {1'b0, quot_y};
        if (neg_x_reg) begin
            step_x = -step_x;
        end
        if (neg_y_reg) begin
            step_y = -step_y;
        end
        if (len_zero_reg) begin
            step_x = '0;
            step_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pixels_left_reg <= '0;
            line_active_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pixels_left_reg <= pixels_left_next;
            line_active_reg <= line_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            neg_x_reg    <= (ex < sx);
            neg_y_reg    <= (ey < sy);
            len_zero_reg <= (len == '0);
        end
    end

    // Sequencer. Steps are served straight from idle; a load runs the dividers in ST_DIVIDE
    // and then stores the signed increments in ST_STORE.
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pixels_left_next = pixels_left_reg;
        line_active_next = line_active_reg;
        div_start        = 1'b0;
        div_en           = 1'b0;
        ctl              = '0;
        case (state_reg)
            ST_IDLE: begin
                if (load_acc) begin
                    div_start        = 1'b1;
                    ctl.load_pos     = 1'b1;
                    cnt_next         = CNT_W'(FRAC_BITS);
                    pixels_left_next = {1'b0, len} + (COORD_BITS+1)'(1);
                    line_active_next = 1'b1;
                    state_next       = ST_DIVIDE;
                end else if (step_acc && line_active_reg) begin
                    ctl.advance = 1'b1;
                    if (last_pix) begin
                        pixels_left_next = '0;
                        line_active_next = 1'b0;
                    end else begin
                        pixels_left_next = pixels_left_reg - (COORD_BITS+1)'(1);
                    end
                end
            end
            ST_DIVIDE: begin
                div_en = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_STORE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_STORE: begin
                ctl.load_step = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .aclk   (aclk),
        .start  (div_start),
        .enable (div_en),
        .mag    (adx),
        .len    (len),
        .quot   (quot_x)
    );

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .aclk   (aclk),
        .start  (div_start),
        .enable (div_en),
        .mag    (ady),
        .len    (len),
        .quot   (quot_y)
    );

    dda_pix #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_pix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .start_x   (sx),
        .start_y   (sy),
        .step_x    (step_x),
        .step_y    (step_y),
        .last_in   (last_pix),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_y, pixel_x});

    // A new pixel only appears after a step transaction against an active line.
    a_pixel_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(step_acc && line_active_reg))
        else $error("pixel issued without an active line");

    // An idle line has nothing left to emit.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !line_active_reg |-> (pixels_left_reg == '0))
        else $error("inactive line with pixels outstanding");

    // A line ends only by emitting its final pixel.
    a_end_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(line_active_reg) |-> (m_tvalid && m_tlast))
        else $error("line ended without a final pixel");

    // The increments are stored only once the full quotient has been shifted out.
    a_divide_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE) |-> $past(state_reg == ST_DIVIDE && cnt_reg == '0))
        else $error("increments stored before division finished");

endmodule

`default_nettype wire
